// File: src/msie_pkg.sv
package msie_pkg;

    // Command codes carried in the cmd field.
    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_READ    = 3'd1;
    localparam logic [2:0] CMD_CLEAR   = 3'd2;
    localparam logic [2:0] CMD_INJECT  = 3'd3;
    localparam logic [2:0] CMD_EXTRACT = 3'd4;

    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 24;
    localparam int WPROD_W  = 2 * WEIGHT_W;
    localparam int W_W      = 28;
    localparam int PROD_W   = VALUE_W + W_W;
    localparam int TERM_W   = PROD_W - 20;
    localparam int SUM_W    = TERM_W + 1;
    localparam int ACC_W    = 64;
    localparam int FIN_W    = ACC_W - 20;

    localparam logic signed [VALUE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_RDWAIT,
        ST_STEP,
        ST_DRAIN,
        ST_FINAL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       single;
        logic       rd_capture;
        logic       issue;
        logic [1:0] pt_i;
        logic [1:0] pt_j;
        logic       final_capture;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
        logic is_read;
        logic is_extract;
    } t_dp_status;

endpackage

// File: src/monopole_stencil_inject_extract.sv
// Point-source injection and extraction on a 2-D grid of Q16.16 samples.
// The input channel (i_in_valid / o_in_stall) carries one command per beat:
// write a sample, read a sample, clear a 3x3 stencil, inject a weighted
// source into the stencil, or gather the weighted stencil sum. Reads and
// gathers return one beat on the output channel (o_out_valid / i_out_stall).
// Commands run one at a time. Stencil commands step through nine grid
// points, one per cycle, on the grid memory's read and write ports; inject
// does a read-modify-write through a multiply pipeline that drains before
// the next beat, and extract gathers its weighted sum through that pipeline.
// A result sits in an output register, so the next command is accepted
// while it waits; a later result waits until that register is taken.
// Reset clears the controller, the pipeline and the output valid flag; the
// grid memory is not cleared, and samples must be written before they are
// read. While the receiver stalls, the output beat holds unchanged.
module monopole_stencil_inject_extract
    import msie_pkg::*;
#(
    parameter int GRID_X_SIZE = 256,
    parameter int GRID_Z_SIZE = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_cmd,
    input  logic [7:0]                 i_pivot_x,
    input  logic [7:0]                 i_pivot_z,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic signed [WEIGHT_W-1:0] i_weight_x0,
    input  logic signed [WEIGHT_W-1:0] i_weight_x1,
    input  logic signed [WEIGHT_W-1:0] i_weight_x2,
    input  logic signed [WEIGHT_W-1:0] i_weight_z0,
    input  logic signed [WEIGHT_W-1:0] i_weight_z1,
    input  logic signed [WEIGHT_W-1:0] i_weight_z2,
    input  logic                       i_accumulate,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [VALUE_W-1:0]  o_result_value
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    msie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_dp_cmd   (dp_cmd)
    );

    msie_datapath #(
        .GRID_X_SIZE (GRID_X_SIZE),
        .GRID_Z_SIZE (GRID_Z_SIZE)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_dp_cmd       (dp_cmd),
        .i_cmd          (i_cmd),
        .i_pivot_x      (i_pivot_x),
        .i_pivot_z      (i_pivot_z),
        .i_value        (i_value),
        .i_weight_x0    (i_weight_x0),
        .i_weight_x1    (i_weight_x1),
        .i_weight_x2    (i_weight_x2),
        .i_weight_z0    (i_weight_z0),
        .i_weight_z1    (i_weight_z1),
        .i_weight_z2    (i_weight_z2),
        .i_accumulate   (i_accumulate),
        .i_out_stall    (i_out_stall),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .o_result_value (o_result_value)
    );

endmodule

// File: src/msie_ctrl.sv
module msie_ctrl
    import msie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_cmd,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_dp_cmd    o_dp_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_i;
    logic [1:0] n_i;
    logic [1:0] r_j;
    logic [1:0] n_j;
    logic       last_point;

    assign last_point = (r_i == 2'd2) && (r_j == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= 2'd0;
            r_j     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    // Next state and stencil point counters.
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        case (r_state)
            ST_IDLE: begin
                n_i = 2'd0;
                n_j = 2'd0;
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_WRITE, CMD_READ:                n_state = ST_SINGLE;
                        CMD_CLEAR, CMD_INJECT, CMD_EXTRACT: n_state = ST_STEP;
                        default:                            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SINGLE: begin
                n_state = i_status.is_read ? ST_RDWAIT : ST_IDLE;
            end
            ST_RDWAIT: begin
                n_state = ST_OUT;
            end
            ST_STEP: begin
                if (last_point) begin
                    n_state = ST_DRAIN;
                end else if (r_j == 2'd2) begin
                    n_j = 2'd0;
                    n_i = r_i + 2'd1;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = i_status.is_extract ? ST_FINAL : ST_IDLE;
                end
            end
            ST_FINAL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_dp_cmd               = '0;
        o_dp_cmd.pt_i          = 2'd1;
        o_dp_cmd.pt_j          = 2'd1;
        o_in_stall             = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall    = 1'b0;
                o_dp_cmd.load = i_in_valid;
            end
            ST_SINGLE: begin
                o_dp_cmd.single = 1'b1;
            end
            ST_RDWAIT: begin
                o_dp_cmd.rd_capture = 1'b1;
            end
            ST_STEP: begin
                o_dp_cmd.issue = 1'b1;
                o_dp_cmd.pt_i  = r_i;
                o_dp_cmd.pt_j  = r_j;
            end
            ST_FINAL: begin
                o_dp_cmd.final_capture = 1'b1;
            end
            ST_OUT: begin
                o_dp_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: src/msie_datapath.sv
module msie_datapath
    import msie_pkg::*;
#(
    parameter int GRID_X_SIZE = 256,
    parameter int GRID_Z_SIZE = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_dp_cmd,
    input  logic [2:0]                 i_cmd,
    input  logic [7:0]                 i_pivot_x,
    input  logic [7:0]                 i_pivot_z,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic signed [WEIGHT_W-1:0] i_weight_x0,
    input  logic signed [WEIGHT_W-1:0] i_weight_x1,
    input  logic signed [WEIGHT_W-1:0] i_weight_x2,
    input  logic signed [WEIGHT_W-1:0] i_weight_z0,
    input  logic signed [WEIGHT_W-1:0] i_weight_z1,
    input  logic signed [WEIGHT_W-1:0] i_weight_z2,
    input  logic                       i_accumulate,
    input  logic                       i_out_stall,
    output t_dp_status                 o_status,
    output logic                       o_out_valid,
    output logic signed [VALUE_W-1:0]  o_result_value
);

    localparam int XW    = $clog2(GRID_X_SIZE);
    localparam int ZW    = $clog2(GRID_Z_SIZE);
    localparam int CELLS = GRID_X_SIZE * GRID_Z_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int KXW   = (XW > 8) ? XW : 8;
    localparam int KZW   = (ZW > 8) ? ZW : 8;

    localparam logic [KXW-1:0] X_LAST = KXW'(GRID_X_SIZE - 1);
    localparam logic [KXW-1:0] X_HI   = KXW'(GRID_X_SIZE - 2);
    localparam logic [KZW-1:0] Z_LAST = KZW'(GRID_Z_SIZE - 1);
    localparam logic [KZW-1:0] Z_HI   = KZW'(GRID_Z_SIZE - 2);
    localparam logic [AW-1:0]  Z_SPAN = AW'(GRID_Z_SIZE);

    localparam logic signed [WPROD_W-1:0] HALF_W    = WPROD_W'(1 << 19);
    localparam logic signed [PROD_W-1:0]  HALF_PROD = PROD_W'(1 << 19);
    localparam logic signed [ACC_W-1:0]   HALF_ACC  = ACC_W'(1 << 19);

    // Latched item.
    logic [2:0]                 r_cmd;
    logic [XW-1:0]              r_px;
    logic [ZW-1:0]              r_pz;
    logic signed [VALUE_W-1:0]  r_value;
    logic signed [WEIGHT_W-1:0] r_wx [3];
    logic signed [WEIGHT_W-1:0] r_wz [3];

    logic [VALUE_W-1:0]         r_mem [CELLS];
    logic [VALUE_W-1:0]         r_rdata;

    // Stencil pipeline.
    logic                       r1_v, r2_v, r3_v, r4_v;
    logic signed [WPROD_W-1:0]  r1_wprod;
    logic [AW-1:0]              r1_addr, r2_addr, r3_addr, r4_addr;
    logic signed [W_W-1:0]      r2_w;
    logic signed [VALUE_W-1:0]  r2_data, r3_data, r4_data;
    logic signed [PROD_W-1:0]   r3_prod;
    logic signed [TERM_W-1:0]   r4_term;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [VALUE_W-1:0]  r_res;
    logic                       r_out_valid;
    logic signed [VALUE_W-1:0]  r_out_value;

    logic [KXW-1:0]             k_px, c_ax, c_px;
    logic [KZW-1:0]             k_pz, c_az, c_pz;
    logic                       is_single_cmd;
    logic [XW:0]                x_sum;
    logic [ZW:0]                z_sum;
    logic [XW-1:0]              x_coord;
    logic [ZW-1:0]              z_coord;
    logic [AW-1:0]              addr;
    logic signed [WEIGHT_W-1:0] sel_wx, sel_wz;
    logic signed [WPROD_W-1:0]  w_rnd;
    logic signed [VALUE_W-1:0]  mult_b;
    logic signed [PROD_W-1:0]   term_rnd;
    logic signed [SUM_W-1:0]    s4_sum;
    logic signed [VALUE_W-1:0]  s4_sat;
    logic signed [ACC_W-1:0]    f_rnd;
    logic signed [FIN_W-1:0]    f_sh;
    logic signed [VALUE_W-1:0]  f_sat;
    logic                       is_inject;
    logic                       is_extract;
    logic                       we;
    logic [AW-1:0]              wr_addr;
    logic [VALUE_W-1:0]         wr_data;
    logic                       out_free;

    assign is_inject  = (r_cmd == CMD_INJECT);
    assign is_extract = (r_cmd == CMD_EXTRACT);

    // Sample addresses saturate at the far edge; stencil pivots keep one
    // point of margin on both sides.
    assign k_px          = KXW'(i_pivot_x);
    assign k_pz          = KZW'(i_pivot_z);
    assign c_ax          = (k_px > X_LAST) ? X_LAST : k_px;
    assign c_az          = (k_pz > Z_LAST) ? Z_LAST : k_pz;
    assign c_px          = (k_px < KXW'(1)) ? KXW'(1) : ((k_px > X_HI) ? X_HI : k_px);
    assign c_pz          = (k_pz < KZW'(1)) ? KZW'(1) : ((k_pz > Z_HI) ? Z_HI : k_pz);
    assign is_single_cmd = (i_cmd == CMD_WRITE) || (i_cmd == CMD_READ);

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd   <= i_cmd;
            r_px    <= is_single_cmd ? XW'(c_ax) : XW'(c_px);
            r_pz    <= is_single_cmd ? ZW'(c_az) : ZW'(c_pz);
            r_value <= i_value;
            r_wx[0] <= i_weight_x0;
            r_wx[1] <= i_weight_x1;
            r_wx[2] <= i_weight_x2;
            r_wz[0] <= i_weight_z0;
            r_wz[1] <= i_weight_z1;
            r_wz[2] <= i_weight_z2;
        end
    end

    // The point offset is pt - 1; a single access uses the centre.
    assign x_sum   = {1'b0, r_px} + (XW + 1)'(i_dp_cmd.pt_i);
    assign z_sum   = {1'b0, r_pz} + (ZW + 1)'(i_dp_cmd.pt_j);
    assign x_coord = XW'(x_sum - (XW + 1)'(1));
    assign z_coord = ZW'(z_sum - (ZW + 1)'(1));
    assign addr    = AW'(x_coord) * Z_SPAN + AW'(z_coord);

    always_comb begin
        case (i_dp_cmd.pt_i)
            2'd0:    sel_wx = r_wx[0];
            2'd1:    sel_wx = r_wx[1];
            default: sel_wx = r_wx[2];
        endcase
        case (i_dp_cmd.pt_j)
            2'd0:    sel_wz = r_wz[0];
            2'd1:    sel_wz = r_wz[1];
            default: sel_wz = r_wz[2];
        endcase
    end

    // Writes come from a single write or a clear at the issue address, or
    // from the last inject stage.
    always_comb begin
        we      = 1'b0;
        wr_addr = addr;
        wr_data = '0;
        if (r4_v && is_inject) begin
            we      = 1'b1;
            wr_addr = r4_addr;
            wr_data = s4_sat;
        end else if (i_dp_cmd.single && (r_cmd == CMD_WRITE)) begin
            we      = 1'b1;
            wr_data = r_value;
        end else if (i_dp_cmd.issue && (r_cmd == CMD_CLEAR)) begin
            we      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[addr];
    end

    assign w_rnd    = r1_wprod + HALF_W;
    assign mult_b   = is_inject ? r_value : r2_data;
    assign term_rnd = r3_prod + HALF_PROD;
    assign s4_sum   = SUM_W'(r4_data) + SUM_W'(r4_term);
    assign s4_sat   = (s4_sum > SUM_W'(SAT_MAX)) ? SAT_MAX :
                      ((s4_sum < SUM_W'(SAT_MIN)) ? SAT_MIN : VALUE_W'(s4_sum));
    assign f_rnd    = r_acc + HALF_ACC;
    assign f_sh     = f_rnd[ACC_W-1:20];
    assign f_sat    = (f_sh > FIN_W'(SAT_MAX)) ? SAT_MAX :
                      ((f_sh < FIN_W'(SAT_MIN)) ? SAT_MIN : VALUE_W'(f_sh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_dp_cmd.issue && (is_inject || is_extract);
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_wprod <= sel_wx * sel_wz;
        r1_addr  <= addr;
        r2_w     <= w_rnd[WPROD_W-1:20];
        r2_data  <= $signed(r_rdata);
        r2_addr  <= r1_addr;
        r3_prod  <= PROD_W'(r2_w) * PROD_W'(mult_b);
        r3_data  <= r2_data;
        r3_addr  <= r2_addr;
        r4_term  <= term_rnd[PROD_W-1:20];
        r4_data  <= r3_data;
        r4_addr  <= r3_addr;
    end

    // The gather starts from the prior trace sample, already at Q.36.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_acc <= i_accumulate ? (ACC_W'(i_value) <<< 20) : '0;
        end else if (r3_v && is_extract) begin
            r_acc <= r_acc + ACC_W'(r3_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.rd_capture) begin
            r_res <= $signed(r_rdata);
        end else if (i_dp_cmd.final_capture) begin
            r_res <= f_sat;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_dp_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            r_out_value <= r_res;
        end
    end

    assign o_status.pipe_busy  = r1_v || r2_v || r3_v || r4_v;
    assign o_status.out_free   = out_free;
    assign o_status.is_read    = (r_cmd == CMD_READ);
    assign o_status.is_extract = is_extract;
    assign o_out_valid         = r_out_valid;
    assign o_result_value      = r_out_value;

endmodule
